@@ design/lisb_pkg.sv @@
package lisb_pkg;

  localparam int MAX_LINES = 1024;
  localparam int IDX_W = $clog2(MAX_LINES + 1);
  localparam int OFF_W = 24;

  // Table is split by index parity so that start[k] and start[k+1] come out together
  localparam int BANK_DEPTH = MAX_LINES / 2 + 1;
  localparam int BANK_AW = $clog2(BANK_DEPTH);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

endpackage

@@ design/lisb_if.sv @@
interface lisb_req_if import lisb_pkg::*;;
  logic             valid;
  logic             ready;
  op_t              opcode;
  logic [IDX_W-1:0] entry_index;
  logic [OFF_W-1:0] entry_offset;
  logic [OFF_W-1:0] query_offset;

  modport source (output valid, opcode, entry_index, entry_offset, query_offset,
                  input ready);
  modport sink (input valid, opcode, entry_index, entry_offset, query_offset,
                output ready);
endinterface

interface lisb_rsp_if import lisb_pkg::*;;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] line_index;
  logic             found;

  modport source (output valid, line_index, found, input ready);
  modport sink (input valid, line_index, found, output ready);
endinterface

@@ design/line_index_binary_search_top.sv @@
// Write item: no response; the next item is taken the cycle after.
// Query item: each probe is a bank read, then a compare; at most 11 probes for
// 1025 entries, then the empty-range exit on a miss and the load of the response.
// The response register frees input; no new item is taken before it is loaded.
// Synchronous reset clears the FSM, line_count, current_line and the response valid;
// the line start table is not cleared and holds garbage until written.
module line_index_binary_search_top import lisb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_wdata,
  lisb_req_if.sink         req,
  lisb_rsp_if.source       rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_DONE
  } state_t;

  state_t                  state;
  logic [IDX_W-1:0]        line_count;
  logic [IDX_W-1:0]        current_line;
  logic [IDX_W-1:0]        last;
  logic [OFF_W-1:0]        q;
  logic signed [IDX_W:0]   lo;
  logic signed [IDX_W:0]   hi;
  logic [IDX_W:0]          mid_sum;
  logic [IDX_W-1:0]        mid_probe;
  logic [IDX_W-1:0]        mid;
  logic                    hit;
  logic                    out_valid;
  logic [IDX_W-1:0]        out_line;
  logic                    out_found;

  logic [OFF_W-1:0]        bank_even [BANK_DEPTH];
  logic [OFF_W-1:0]        bank_odd  [BANK_DEPTH];
  logic [OFF_W-1:0]        rd_even;
  logic [OFF_W-1:0]        rd_odd;
  logic [BANK_AW-1:0]      half;
  logic [BANK_AW-1:0]      rd_addr_even;
  logic [BANK_AW-1:0]      wr_addr;
  logic                    wr_en;
  logic [OFF_W-1:0]        start_val;
  logic [OFF_W-1:0]        next_val;
  logic                    req_xfer;

  assign req.ready  = (state == S_IDLE);
  assign req_xfer   = req.valid && req.ready;

  assign rsp.valid      = out_valid;
  assign rsp.line_index = out_line;
  assign rsp.found      = out_found;

  assign last = (line_count > IDX_W'(MAX_LINES)) ? IDX_W'(MAX_LINES) : line_count;

  // lo <= hi implies both are non-negative, so the sum fits unsigned
  assign mid_sum   = IDX_W'(0) + lo + hi;
  assign mid_probe = mid_sum[IDX_W:1];

  assign half         = BANK_AW'(mid_probe >> 1);
  assign rd_addr_even = mid_probe[0] ? half + BANK_AW'(1) : half;

  assign wr_en   = req_xfer && (req.opcode == OP_WRITE) &&
                   (req.entry_index <= IDX_W'(MAX_LINES));
  assign wr_addr = BANK_AW'(req.entry_index >> 1);

  always_ff @(posedge clk) begin
    if (wr_en && !req.entry_index[0]) begin
      bank_even[wr_addr] <= req.entry_offset;
    end
    rd_even <= bank_even[rd_addr_even];
  end

  always_ff @(posedge clk) begin
    if (wr_en && req.entry_index[0]) begin
      bank_odd[wr_addr] <= req.entry_offset;
    end
    rd_odd <= bank_odd[half];
  end

  assign start_val = mid[0] ? rd_odd : rd_even;
  assign next_val  = mid[0] ? rd_even : rd_odd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      line_count   <= '0;
      current_line <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        line_count <= cfg_wdata;
      end
      // S_DONE reloads the response register itself on a transfer
      if (rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_xfer && req.opcode == OP_QUERY) begin
            q     <= req.query_offset;
            lo    <= '0;
            hi    <= signed'({1'b0, last});
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (lo > hi) begin
            hit   <= 1'b0;
            state <= S_DONE;
          end else begin
            mid   <= mid_probe;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          // q < next stands for q <= next - 1 without the underflow at zero
          if (mid == last) begin
            if (q >= start_val) begin
              hit   <= 1'b1;
              state <= S_DONE;
            end else begin
              hi    <= signed'({1'b0, mid}) - signed'((IDX_W + 1)'(1));
              state <= S_PROBE;
            end
          end else if (q < next_val && q >= start_val) begin
            hit   <= 1'b1;
            state <= S_DONE;
          end else if (q >= next_val) begin
            lo    <= signed'({1'b0, mid}) + signed'((IDX_W + 1)'(1));
            state <= S_PROBE;
          end else begin
            hi    <= signed'({1'b0, mid}) - signed'((IDX_W + 1)'(1));
            state <= S_PROBE;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_found <= hit;
            if (hit) begin
              current_line <= mid;
              out_line     <= mid;
            end else begin
              out_line <= current_line;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/lisb_checker.sv @@
module lisb_assertions import lisb_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [IDX_W-1:0] line_index,
  input logic             found
);

  // line of the last delivered response; a miss must repeat it
  logic [IDX_W-1:0] last_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_line <= '0;
    end else if (rsp_valid && rsp_ready) begin
      last_line <= line_index;
    end
  end

  a_rst_no_rsp: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(line_index) && $stable(found))
    else $error("stalled response changed");

  a_miss_keeps_line: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !found |-> line_index == last_line)
    else $error("miss did not return the previous line");

  a_line_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> line_index <= IDX_W'(MAX_LINES))
    else $error("line index beyond table");

endmodule

bind line_index_binary_search_top lisb_assertions u_lisb_assertions (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .line_index (rsp.line_index),
  .found      (rsp.found)
);

@@ dv/lisb_checker.sv @@
module lisb_checker import lisb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_wdata,
  lisb_req_if              req,
  lisb_rsp_if              rsp,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W-1:0] line;
    logic             found;
  } line_hit_t;

  logic [OFF_W-1:0] line_starts_copy [0:MAX_LINES];
  logic [IDX_W-1:0] line_count_copy;
  logic [IDX_W-1:0] current_line_copy;
  line_hit_t        expected_lines [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report_mismatch(string msg);
    $display("%0t ERROR %s", $time, msg);
    fail_count++;
  endtask

  // Binary search over the start table; a hit is the span start[k]..start[k+1]-1,
  // the last line takes everything at or above its start.
  function automatic line_hit_t locate_line(logic [OFF_W-1:0] offset);
    int q, last, lo, hi, mid, span_end;
    bit done;
    line_hit_t res;
    q = offset;
    last = (line_count_copy > MAX_LINES) ? MAX_LINES : line_count_copy;
    lo = 0;
    hi = last;
    done = 0;
    res.found = 1'b0;
    res.line = current_line_copy;
    while (!done && lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (mid == last) begin
        if (q >= int'(line_starts_copy[mid])) begin
          res.found = 1'b1;
          res.line = IDX_W'(mid);
          done = 1;
        end else begin
          hi = mid - 1;
        end
      end else begin
        span_end = int'(line_starts_copy[mid + 1]) - 1;
        if (q <= span_end && q >= int'(line_starts_copy[mid])) begin
          res.found = 1'b1;
          res.line = IDX_W'(mid);
          done = 1;
        end else if (q > span_end) begin
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    line_hit_t want;
    if (rst) begin
      line_count_copy = '0;
      current_line_copy = '0;
      expected_lines.delete();
    end else begin
      // compare before pushing so a stray response cannot pair with a new query
      if (rsp.valid && rsp.ready) begin
        if (expected_lines.size() == 0) begin
          report_mismatch($sformatf("unexpected response line=%0d found=%0b",
                                    rsp.line_index, rsp.found));
        end else begin
          want = expected_lines.pop_front();
          if (rsp.line_index !== want.line)
            report_mismatch($sformatf("line_index %0d, expected %0d",
                                      rsp.line_index, want.line));
          if (rsp.found !== want.found)
            report_mismatch($sformatf("found %0b, expected %0b", rsp.found, want.found));
        end
      end
      if (req.valid && req.ready) begin
        if (req.opcode == OP_WRITE) begin
          if (req.entry_index <= MAX_LINES)
            line_starts_copy[req.entry_index] = req.entry_offset;
        end else begin
          want = locate_line(req.query_offset);
          if (want.found)
            current_line_copy = want.line;
          want.line = current_line_copy;
          expected_lines.push_back(want);
        end
      end
      if (cfg_we)
        line_count_copy = cfg_wdata;
    end
    pending = expected_lines.size();
  end

endmodule

@@ dv/testbench.sv @@
module testbench import lisb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OFF_MAX = 2 ** OFF_W - 1;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT = 1100;
  localparam int PHASE_ITEMS = 58;
  localparam int NUM_PHASES = 7;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_wdata;
  int               fail_count;
  int               pending;
  int               transfers = 0;
  int               quiet_cycles = 0;
  int               hold_left = 0;
  bit               hold_done = 0;
  bit               calm = 0;
  logic [OFF_W-1:0] table_shadow [0:MAX_LINES];

  lisb_req_if req_ch();
  lisb_rsp_if rsp_ch();

  line_index_binary_search_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  lisb_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Response side: random back-pressure, plus one long hold-off to fill the block
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (!hold_done && transfers >= HOLD_AT) begin
      hold_done = 1;
      hold_left = HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= calm || ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("line_index_binary_search_top regression: fail");
      $finish;
    end
  end

  task automatic send_item(op_t op, logic [IDX_W-1:0] slot, logic [OFF_W-1:0] value,
                           logic [OFF_W-1:0] offset);
    while (!calm && $urandom_range(99) < 9) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.opcode       <= op;
    req_ch.entry_index  <= slot;
    req_ch.entry_offset <= value;
    req_ch.query_offset <= offset;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    transfers++;
    if (op == OP_WRITE && slot <= MAX_LINES)
      table_shadow[slot] = value;
    @(negedge clk);
  endtask

  task automatic write_entry(int slot, int value);
    send_item(OP_WRITE, IDX_W'(slot), OFF_W'(value), OFF_W'($urandom));
  endtask

  task automatic query(int offset);
    send_item(OP_QUERY, IDX_W'($urandom), OFF_W'($urandom), OFF_W'(offset));
  endtask

  // no transfer in flight: all responses in, then let a trailing write finish
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_line_count(int count);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= IDX_W'(count);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly offsets inside or at the edges of valid spans, some below the first start or random
  function automatic int pick_query(int last);
    int k, lo, hi;
    k = $urandom_range(last, 0);
    lo = table_shadow[k];
    hi = (k < last) ? int'(table_shadow[k + 1]) - 1 : OFF_MAX;
    case ($urandom_range(9))
      0, 1, 2, 3: return (lo <= hi) ? int'($urandom_range(hi, lo)) : lo;
      4, 5:       return lo;
      6:          return (hi >= 0) ? hi : 0;
      7:          return (table_shadow[0] > 0) ? int'($urandom_range(table_shadow[0] - 1)) : 0;
      8:          return $urandom_range(OFF_MAX, table_shadow[last]);
      default:    return $urandom_range(OFF_MAX);
    endcase
  endfunction

  // keeps the table ascending, with the odd arbitrary or out-of-range write
  task automatic random_write();
    int k, lo, hi;
    if ($urandom_range(19) == 0) begin
      write_entry($urandom_range(2 ** IDX_W - 1), $urandom_range(OFF_MAX));
    end else begin
      k = $urandom_range(MAX_LINES);
      lo = (k == 0) ? 0 : int'(table_shadow[k - 1]) + 1;
      hi = (k == MAX_LINES) ? OFF_MAX : int'(table_shadow[k + 1]) - 1;
      write_entry(k, (lo <= hi) ? int'($urandom_range(hi, lo)) : int'(table_shadow[k]));
    end
  endtask

  initial begin
    int start;
    int keep;
    int last;
    int phase_counts [NUM_PHASES];

    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    req_ch.valid        = 1'b0;
    req_ch.opcode       = OP_WRITE;
    req_ch.entry_index  = '0;
    req_ch.entry_offset = '0;
    req_ch.query_offset = '0;
    rsp_ch.ready        = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // fill every slot so no search can touch an unwritten entry
    start = 0;
    for (int k = 0; k < MAX_LINES; k++) begin
      write_entry(k, start);
      start += $urandom_range(16000, 200);
    end
    write_entry(MAX_LINES, OFF_MAX);

    // line_count still at reset value: single line, offset below its start misses
    write_entry(0, 100);
    query(0);
    query(100);
    query(OFF_MAX);

    set_line_count(MAX_LINES);
    query(OFF_MAX);
    query(OFF_MAX - 1);
    query(table_shadow[512]);
    query(int'(table_shadow[513]) - 1);
    query(0);
    write_entry(MAX_LINES + 1, 0);
    write_entry(2 ** IDX_W - 1, 0);
    query(50);
    // out-of-order table: the search has to terminate anyway
    keep = table_shadow[300];
    write_entry(300, OFF_MAX - 15);
    query(keep);
    query(table_shadow[301]);
    write_entry(300, keep);

    set_line_count(2 ** IDX_W - 1);
    query(OFF_MAX);
    query(0);

    phase_counts[0] = 1;
    phase_counts[1] = 2;
    phase_counts[2] = 0;
    phase_counts[3] = MAX_LINES;
    phase_counts[4] = $urandom_range(MAX_LINES - 1, 3);
    phase_counts[5] = $urandom_range(40, 3);
    phase_counts[6] = $urandom_range(2 ** IDX_W - 1, MAX_LINES + 1);
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_line_count(phase_counts[p]);
      last = (phase_counts[p] > MAX_LINES) ? MAX_LINES : phase_counts[p];
      calm = (p == 3);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(4) == 0)
          random_write();
        else
          query(pick_query(last));
      end
    end
    calm = 0;

    settle();
    if (fail_count == 0) begin
      $display("line_index_binary_search_top regression: pass");
    end else begin
      $display("line_index_binary_search_top regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/lisb_pkg.sv
design/lisb_if.sv
design/line_index_binary_search_top.sv
design/lisb_checker.sv
dv/lisb_checker.sv
dv/testbench.sv
